[sv/assert_macros.svh]
// assertion helpers included by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define IRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define IRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/irs_pkg.sv]
package irs_pkg;

  // command codes
  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_MANUAL      = 3'd1;
  localparam logic [2:0] OP_STOP        = 3'd2;
  localparam logic [2:0] OP_RELOAD_PUMP = 3'd3;
  localparam logic [2:0] OP_RELOAD_IRR  = 3'd4;

  // channel modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_PUMP_ONE  = 2'd1;
  localparam logic [1:0] REG_PUMP_TWO  = 2'd2;

  // register reset values
  localparam logic [31:0] INTERVAL_RST = 32'd3600000;
  localparam logic [31:0] PUMP_RST     = 32'd10000;

  // command as seen by one channel
  typedef struct packed {
    logic [2:0] op;
    logic       sel;
  } irs_cmd_t;

  function automatic logic is_pumping(input logic [1:0] mode);
    return (mode == MODE_MANUAL) || (mode == MODE_AUTO);
  endfunction

endpackage

[sv/irs_if.sv]
// command channel
interface irs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  channel_mask;
  logic [31:0] delta;

  modport source (output valid, op, channel_mask, delta, input ready);
  modport sink (input valid, op, channel_mask, delta, output ready);
endinterface

// status channel
interface irs_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [1:0]  mode_one;
  logic [1:0]  mode_two;
  logic [31:0] pump_left_one;
  logic [31:0] pump_left_two;
  logic [31:0] interval_left;
  logic        any_pumping;

  modport source (output valid, ok, mode_one, mode_two, pump_left_one, pump_left_two,
                  interval_left, any_pumping, input ready);
  modport sink (input valid, ok, mode_one, mode_two, pump_left_one, pump_left_two,
                interval_left, any_pumping, output ready);
endinterface

// register write channel
interface irs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/irs_channel.sv]
module irs_channel
  import irs_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  irs_cmd_t              cmd,
  input  logic [TIME_WIDTH-1:0] delta,
  input  logic [TIME_WIDTH-1:0] pump_time,
  input  logic [TIME_WIDTH-1:0] reload_val,
  input  logic [TIME_WIDTH-1:0] interval_in,
  input  logic [1:0]            mode,
  input  logic [TIME_WIDTH-1:0] pump_left,
  output logic [1:0]            mode_nxt,
  output logic [TIME_WIDTH-1:0] pump_left_nxt,
  output logic [TIME_WIDTH-1:0] interval_out,
  output logic                  ok
);

  logic [TIME_WIDTH-1:0] pump_dec;

  // saturating countdown
  assign pump_dec = (pump_left > delta) ? (pump_left - delta) : '0;

  always_comb begin
    mode_nxt      = mode;
    pump_left_nxt = pump_left;
    interval_out  = interval_in;
    ok            = 1'b0;
    case (cmd.op)
      OP_TICK: begin
        pump_left_nxt = pump_dec;
        if (mode == MODE_IDLE) begin
          if (interval_in == '0) begin
            // shared timer expired: start auto watering
            mode_nxt      = MODE_AUTO;
            pump_left_nxt = pump_time;
            interval_out  = '0;
            ok            = 1'b1;
          end
        end else if (is_pumping(mode) && (pump_dec == '0)) begin
          mode_nxt      = MODE_IDLE;
          pump_left_nxt = '0;
          interval_out  = reload_val;
          ok            = 1'b1;
        end
      end
      OP_MANUAL: begin
        if (cmd.sel && (mode == MODE_IDLE)) begin
          mode_nxt      = MODE_MANUAL;
          pump_left_nxt = pump_time;
          ok            = 1'b1;
        end
      end
      OP_STOP: begin
        if (cmd.sel && is_pumping(mode)) begin
          mode_nxt      = MODE_IDLE;
          pump_left_nxt = '0;
          interval_out  = reload_val;
          ok            = 1'b1;
        end
      end
      OP_RELOAD_PUMP: begin
        if (cmd.sel) begin
          pump_left_nxt = pump_time;
          ok            = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/two_channel_irrigation_sequencer.sv]
// Two pump channels (idle, manual or auto) sharing one watering countdown that
// runs the watering interval less the longer pump time. Every command on in_ch
// gives exactly one status item on out_ch, showing both channels and the shared
// timer after the command. One command is taken per clock while out_ch keeps
// up; a command sits in the input register while the single update pass
// computes its status, which is loaded into the result register that
// drives out_ch. A stalled out_ch backs up into the input register before
// in_ch.ready drops. Register writes on cfg_ch are always ready, ignore zero
// values (after truncation to TIME_WIDTH bits) and never reload a running
// timer; write them only while no command is in flight. Time values are
// TIME_WIDTH bits wide inside; the 32-bit fields are truncated or zero-extended
// to fit.
`include "assert_macros.svh"

module two_channel_irrigation_sequencer
  import irs_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  irs_in_if.sink     in_ch,
  irs_out_if.source  out_ch,
  irs_cfg_if.sink    cfg_ch
);

  // reset values brought to the internal time width
  localparam logic [TIME_WIDTH-1:0] IntervalRst = TIME_WIDTH'(INTERVAL_RST);
  localparam logic [TIME_WIDTH-1:0] PumpRst     = TIME_WIDTH'(PUMP_RST);
  localparam logic [TIME_WIDTH-1:0] LeftRst     =
    (IntervalRst > PumpRst) ? (IntervalRst - PumpRst) : '0;

  // configuration registers
  logic [TIME_WIDTH-1:0] interval_cfg_r;
  logic [TIME_WIDTH-1:0] pump_one_cfg_r;
  logic [TIME_WIDTH-1:0] pump_two_cfg_r;
  logic [TIME_WIDTH-1:0] cfg_value;

  // channel and shared timer state
  logic [1:0]            mode_one_r, mode_two_r;
  logic [TIME_WIDTH-1:0] pump_one_r, pump_two_r;
  logic [TIME_WIDTH-1:0] interval_r;

  // input register
  logic                  s1_valid_r;
  logic [2:0]            s1_op_r;
  logic [1:0]            s1_mask_r;
  logic [TIME_WIDTH-1:0] s1_delta_r;
  logic                  s1_adv;

  // result register
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [1:0]            out_mode_one_r, out_mode_two_r;
  logic [31:0]           out_pump_one_r, out_pump_two_r, out_interval_r;
  logic                  out_any_r;

  // update pass
  logic [TIME_WIDTH-1:0] longest;
  logic [TIME_WIDTH-1:0] reload_val;
  logic [TIME_WIDTH-1:0] interval_ticked;
  irs_cmd_t              cmd_one, cmd_two;
  logic [1:0]            mode_one_nxt, mode_two_nxt;
  logic [TIME_WIDTH-1:0] pump_one_nxt, pump_two_nxt;
  logic [TIME_WIDTH-1:0] interval_mid, interval_ch;
  logic [TIME_WIDTH-1:0] interval_nxt;
  logic                  ok_one, ok_two, ok_nxt;

  // ---------------------------------------------------------------------------
  // register writes
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_value    = TIME_WIDTH'(cfg_ch.data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_cfg_r <= IntervalRst;
      pump_one_cfg_r <= PumpRst;
      pump_two_cfg_r <= PumpRst;
    end else if (cfg_ch.valid && (cfg_value != '0)) begin
      unique case (cfg_ch.index)
        REG_INTERVAL: interval_cfg_r <= cfg_value;
        REG_PUMP_ONE: pump_one_cfg_r <= cfg_value;
        REG_PUMP_TWO: pump_two_cfg_r <= cfg_value;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register moves on when the result register is free
  // or is being emptied in the same cycle
  // ---------------------------------------------------------------------------
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r    <= in_ch.op;
      s1_mask_r  <= in_ch.channel_mask;
      s1_delta_r <= TIME_WIDTH'(in_ch.delta);
    end
  end

  // ---------------------------------------------------------------------------
  // update pass
  // ---------------------------------------------------------------------------
  // shared timer reload value: interval less the longer pump time, floor zero
  assign longest    = (pump_one_cfg_r > pump_two_cfg_r) ? pump_one_cfg_r : pump_two_cfg_r;
  assign reload_val = (interval_cfg_r > longest) ? (interval_cfg_r - longest) : '0;

  // a tick lowers the shared timer before either channel looks at it
  assign interval_ticked = (s1_op_r == OP_TICK) ?
                           ((interval_r > s1_delta_r) ? (interval_r - s1_delta_r) : '0) :
                           interval_r;

  assign cmd_one = '{op: s1_op_r, sel: s1_mask_r[0]};
  assign cmd_two = '{op: s1_op_r, sel: s1_mask_r[1]};

  // channel one first, its shared timer result feeds channel two
  irs_channel #(.TIME_WIDTH(TIME_WIDTH)) u_ch_one (
    .cmd           (cmd_one),
    .delta         (s1_delta_r),
    .pump_time     (pump_one_cfg_r),
    .reload_val    (reload_val),
    .interval_in   (interval_ticked),
    .mode          (mode_one_r),
    .pump_left     (pump_one_r),
    .mode_nxt      (mode_one_nxt),
    .pump_left_nxt (pump_one_nxt),
    .interval_out  (interval_mid),
    .ok            (ok_one)
  );

  irs_channel #(.TIME_WIDTH(TIME_WIDTH)) u_ch_two (
    .cmd           (cmd_two),
    .delta         (s1_delta_r),
    .pump_time     (pump_two_cfg_r),
    .reload_val    (reload_val),
    .interval_in   (interval_mid),
    .mode          (mode_two_r),
    .pump_left     (pump_two_r),
    .mode_nxt      (mode_two_nxt),
    .pump_left_nxt (pump_two_nxt),
    .interval_out  (interval_ch),
    .ok            (ok_two)
  );

  // watering timer reload only takes effect while the timer still runs
  always_comb begin
    interval_nxt = interval_ch;
    ok_nxt       = ok_one || ok_two;
    if (s1_op_r == OP_RELOAD_IRR) begin
      ok_nxt = (interval_r != '0);
      if (interval_r != '0) begin
        interval_nxt = reload_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_one_r <= MODE_IDLE;
      mode_two_r <= MODE_IDLE;
      pump_one_r <= '0;
      pump_two_r <= '0;
      interval_r <= LeftRst;
    end else if (s1_adv) begin
      mode_one_r <= mode_one_nxt;
      mode_two_r <= mode_two_nxt;
      pump_one_r <= pump_one_nxt;
      pump_two_r <= pump_two_nxt;
      interval_r <= interval_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ok_r       <= ok_nxt;
      out_mode_one_r <= mode_one_nxt;
      out_mode_two_r <= mode_two_nxt;
      out_pump_one_r <= 32'(pump_one_nxt);
      out_pump_two_r <= 32'(pump_two_nxt);
      out_interval_r <= 32'(interval_nxt);
      out_any_r      <= is_pumping(mode_one_nxt) || is_pumping(mode_two_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.mode_one      = out_mode_one_r;
  assign out_ch.mode_two      = out_mode_two_r;
  assign out_ch.pump_left_one = out_pump_one_r;
  assign out_ch.pump_left_two = out_pump_two_r;
  assign out_ch.interval_left = out_interval_r;
  assign out_ch.any_pumping   = out_any_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the input side only stalls behind a full, stalled result register
  `IRS_ASSERT_NOW(a_ready_only_on_stall, !in_ch.ready,
    s1_valid_r && out_valid_r && !out_ch.ready, "input stalled without output backpressure")

  // every update pass leaves a result behind it
  `IRS_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_r,
    "update pass did not load the result register")

  // channel state only moves with an update pass
  `IRS_ASSERT_NEXT(a_state_holds, !s1_adv,
    $stable(mode_one_r) && $stable(mode_two_r) && $stable(pump_one_r) &&
    $stable(pump_two_r) && $stable(interval_r), "state changed without a command")

endmodule
